@@ rtl/frame_difference_motion_detect_assert.svh @@
// assertion macros shared by fdmd_front, fdmd_queue and fdmd_back
`ifndef FRAME_DIFFERENCE_MOTION_DETECT_ASSERT_SVH
`define FRAME_DIFFERENCE_MOTION_DETECT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define FDMD_ASSERT_HOLDS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// consequence holds at the same edge as the antecedent
`define FDMD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// consequence holds at the edge after the antecedent
`define FDMD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/fdmd_pkg.sv @@
package fdmd_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int PIXEL_RANGE = 255;
    localparam int PIX_W       = 8;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int CFG_DIM_W   = 13;
    localparam int PCT_W       = 7;
    localparam int PML_W       = 10;
    localparam int TOL_W       = 9;
    localparam int COUNT_W     = 25;
    localparam int AREA_W      = 2 * DIM_W + 1;
    localparam int SCALED_W    = 35;
    localparam int COUNT_SCALE = 1000;

    // floor(x / 100) as (x * 5243) >> 19, exact for x below 32768
    localparam int SCALED_PCT_W = 15;
    localparam int TOL_RECIP    = 5243;
    localparam int TOL_SHIFT    = 19;
    localparam int TOL_PROD_W   = 28;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [PCT_W-1:0]     RST_TOL_PCT = PCT_W'(10);
    localparam logic [PML_W-1:0]     RST_QTY_PML = PML_W'(10);
    localparam logic [CFG_DIM_W-1:0] RST_WIDTH   = CFG_DIM_W'(640);
    localparam logic [CFG_DIM_W-1:0] RST_HEIGHT  = CFG_DIM_W'(480);
    localparam logic [TOL_W-1:0]     RST_TOL     = TOL_W'((PIXEL_RANGE * 10) / 100);
    localparam logic [AREA_W-1:0]    RST_AREA    = AREA_W'(640 * 480);
    localparam logic [SCALED_W-1:0]  RST_THR     = SCALED_W'(640 * 480 * 10);

    typedef enum logic [1:0] {
        REG_TOL_PCT = 2'd0,
        REG_QTY_PML = 2'd1,
        REG_WIDTH   = 2'd2,
        REG_HEIGHT  = 2'd3
    } reg_idx_t;

    // one classified pixel travelling from front to back
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [2:0]       flags;   // bit0 blue, bit1 green, bit2 red
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        logic             last;
    } item_t;

    function automatic logic [TOL_W-1:0] tol_of(input logic [PCT_W-1:0] pct);
        logic [SCALED_PCT_W-1:0] scaled;
        logic [TOL_PROD_W-1:0]   prod;
        scaled = SCALED_PCT_W'(pct) * SCALED_PCT_W'(PIXEL_RANGE);
        prod   = TOL_PROD_W'(scaled) * TOL_PROD_W'(TOL_RECIP);
        return prod[TOL_SHIFT +: TOL_W];
    endfunction

    function automatic logic [CFG_DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] d);
        logic [CFG_DIM_W-1:0] r;
        if (d == '0) begin
            r = CFG_DIM_W'(1);
        end else if (d > CFG_DIM_W'(MAX_DIM)) begin
            r = CFG_DIM_W'(MAX_DIM);
        end else begin
            r = d;
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ rtl/fdmd_front.sv @@
module fdmd_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [47:0]                       s_tdata,
    input  logic [fdmd_pkg::TOL_W-1:0]        tol,
    input  logic [fdmd_pkg::CFG_DIM_W-1:0]    width_eff,
    input  logic [fdmd_pkg::CFG_DIM_W-1:0]    height_eff,
    input  logic                              q_full,
    output logic                              q_push,
    output fdmd_pkg::item_t                   q_item
);

    `include "frame_difference_motion_detect_assert.svh"

    logic [fdmd_pkg::DIM_W-1:0] col_reg, row_reg;
    logic [fdmd_pkg::DIM_W-1:0] col_next, row_next;

    logic [fdmd_pkg::PIX_W-1:0] b_red, b_green, b_blue, c_red, c_green, c_blue;
    logic [2:0]  flags;
    logic        changed;
    logic [10:0] blue_x5;
    logic [9:0]  blue_x25;
    logic [fdmd_pkg::PIX_W-1:0] green_tint;
    logic        last_col, last_row, last;

    assign b_red   = s_tdata[7:0];
    assign b_green = s_tdata[15:8];
    assign b_blue  = s_tdata[23:16];
    assign c_red   = s_tdata[31:24];
    assign c_green = s_tdata[39:32];
    assign c_blue  = s_tdata[47:40];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        flags[0] = {1'b0, fdmd_pkg::abs_diff(b_blue,  c_blue)}  > tol;
        flags[1] = {1'b0, fdmd_pkg::abs_diff(b_green, c_green)} > tol;
        flags[2] = {1'b0, fdmd_pkg::abs_diff(b_red,   c_red)}   > tol;
        changed  = |flags;

        // blue * 5 / 2, clipped to full scale
        blue_x5    = {1'b0, c_blue, 2'b00} + 11'(c_blue);
        blue_x25   = blue_x5[10:1];
        green_tint = (blue_x25 > 10'd255) ? 8'hFF : blue_x25[7:0];

        last_col = ({1'b0, col_reg} + 13'd1) >= width_eff;
        last_row = ({1'b0, row_reg} + 13'd1) >= height_eff;
        last     = last_col && last_row;

        q_item.red   = changed ? {1'b0, c_red[7:1]}  : c_red;
        q_item.green = changed ? green_tint          : c_green;
        q_item.blue  = changed ? {1'b0, c_blue[7:1]} : c_blue;
        q_item.flags = flags;
        q_item.col   = col_reg;
        q_item.row   = row_reg;
        q_item.last  = last;

        if (last) begin
            col_next = '0;
            row_next = '0;
        end else if (last_col) begin
            col_next = '0;
            row_next = row_reg + 1'b1;
        end else begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (q_push) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    `FDMD_ASSERT_NEXT(a_raster_wrap, aclk, aresetn, q_push && q_item.last, (col_reg == '0) && (row_reg == '0), "raster position not cleared after last pixel")

endmodule

@@ rtl/fdmd_queue.sv @@
module fdmd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  fdmd_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output fdmd_pkg::item_t pop_item
);

    `include "frame_difference_motion_detect_assert.svh"

    fdmd_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `FDMD_ASSERT_HOLDS(a_q_bound, aclk, aresetn, count_reg != 2'd3, "queue fill count out of range")
    `FDMD_ASSERT_NEXT(a_q_fill, aclk, aresetn, push && !pop && (count_reg == 2'd1), full, "queue did not fill")
    `FDMD_ASSERT_NEXT(a_q_drain, aclk, aresetn, pop && !push && (count_reg == 2'd1), !valid, "queue did not drain")

endmodule

@@ rtl/fdmd_back.sv @@
module fdmd_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  fdmd_pkg::item_t                  q_item,
    output logic                             q_pop,
    input  logic [fdmd_pkg::SCALED_W-1:0]    thr,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [103:0]                     m_tdata,
    output logic                             m_tlast
);

    `include "frame_difference_motion_detect_assert.svh"

    localparam int DW = fdmd_pkg::DIM_W;

    // frame accumulators
    logic [fdmd_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [fdmd_pkg::SCALED_W-1:0] scaled_reg, scaled_next;
    logic [2:0]    flags_reg, flags_next;
    logic [DW-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic [DW-1:0] min_x_next, min_y_next, max_x_next, max_y_next;

    // output register
    logic          out_valid_reg;
    logic [7:0]    o_red_reg, o_green_reg, o_blue_reg;
    logic          o_last_reg;
    logic [3:0]    o_flags_reg;
    logic [fdmd_pkg::COUNT_W-1:0] o_count_reg;
    logic [DW-1:0] o_min_x_reg, o_min_y_reg, o_max_x_reg, o_max_y_reg;

    logic changed, bump, qty_hit;

    always_comb begin
        q_pop   = q_valid && (!out_valid_reg || m_tready);
        changed = |q_item.flags;
        bump    = changed && (count_reg != fdmd_pkg::COUNT_MAX);

        flags_next  = flags_reg | q_item.flags;
        count_next  = bump ? count_reg + 1'b1 : count_reg;
        // count * 1000 kept alongside, compared against area * permille
        scaled_next = bump ? scaled_reg + fdmd_pkg::SCALED_W'(fdmd_pkg::COUNT_SCALE)
                           : scaled_reg;
        qty_hit     = q_item.last && (scaled_next > thr);

        min_x_next = (changed && (q_item.col < min_x_reg)) ? q_item.col : min_x_reg;
        min_y_next = (changed && (q_item.row < min_y_reg)) ? q_item.row : min_y_reg;
        max_x_next = (changed && (q_item.col > max_x_reg)) ? q_item.col : max_x_reg;
        max_y_next = (changed && (q_item.row > max_y_reg)) ? q_item.row : max_y_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            scaled_reg    <= '0;
            flags_reg     <= '0;
            min_x_reg     <= '1;
            min_y_reg     <= '1;
            max_x_reg     <= '0;
            max_y_reg     <= '0;
        end else begin
            if (q_pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                if (q_item.last) begin
                    count_reg  <= '0;
                    scaled_reg <= '0;
                    flags_reg  <= '0;
                    min_x_reg  <= '1;
                    min_y_reg  <= '1;
                    max_x_reg  <= '0;
                    max_y_reg  <= '0;
                end else begin
                    count_reg  <= count_next;
                    scaled_reg <= scaled_next;
                    flags_reg  <= flags_next;
                    min_x_reg  <= min_x_next;
                    min_y_reg  <= min_y_next;
                    max_x_reg  <= max_x_next;
                    max_y_reg  <= max_y_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            o_red_reg   <= q_item.red;
            o_green_reg <= q_item.green;
            o_blue_reg  <= q_item.blue;
            o_last_reg  <= q_item.last;
            o_flags_reg <= {qty_hit, flags_next};
            o_count_reg <= count_next;
            o_min_x_reg <= min_x_next;
            o_min_y_reg <= min_y_next;
            o_max_x_reg <= max_x_next;
            o_max_y_reg <= max_y_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {3'b000, o_max_y_reg, o_max_x_reg, o_min_y_reg, o_min_x_reg,
                       o_count_reg, o_flags_reg, o_blue_reg, o_green_reg, o_red_reg};

    `FDMD_ASSERT_SAME(a_box_order, aclk, aresetn, out_valid_reg && (o_count_reg != '0), (o_min_x_reg <= o_max_x_reg) && (o_min_y_reg <= o_max_y_reg), "bounding box inverted with changed pixels")
    `FDMD_ASSERT_SAME(a_box_empty, aclk, aresetn, out_valid_reg && (o_count_reg == '0), (o_min_x_reg == '1) && (o_max_x_reg == '0) && (o_min_y_reg == '1) && (o_max_y_reg == '0), "box not empty without changed pixels")

endmodule

@@ rtl/frame_difference_motion_detect.sv @@
// Frame-difference motion detector. Each request on the s_ side carries one co-located pixel
// pair (reference and current frame, 8-bit RGB) in raster order; each request on the m_ side
// carries the output pixel (current pixel, or tinted green = min(255, blue*5/2), red/2,
// blue/2 when any channel differs by more than floor(255*percent/100)) together with the
// running frame summary: sticky per-channel flags, changed-pixel count and bounding box.
// m_tlast marks the last pixel of the frame, where diff_flags bit 3 reports
// count > width*height*permille/1000; all frame state then clears for the next frame.
// One pixel is taken per clock when the result side keeps up; a result passes from the front
// classify through the two-entry queue and then the accumulate stage into the output register,
// and the queue's second entry absorbs a pixel taken while the output stalls.
// Registers on the APB port: 0x0 tolerance_percent,
// 0x4 quantity_permille, 0x8 frame_width, 0xC frame_height; write them while idle.
module frame_difference_motion_detect (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // pixel pairs in
    input  logic         s_tvalid,
    output logic         s_tready,
    // base_red, base_green, base_blue, cur_red, cur_green, cur_blue (8 bits each)
    input  logic [47:0]  s_tdata,
    // results out
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_red, out_green, out_blue (8 each), diff_flags (4), changed_count (25),
    // box_min_x, box_min_y, box_max_x, box_max_y (12 each), 3 zero pad bits
    output logic [103:0] m_tdata,
    output logic         m_tlast     // frame_done
);

    localparam int CDW = fdmd_pkg::CFG_DIM_W;

    // raw register values, as read back
    logic [fdmd_pkg::PCT_W-1:0] tol_pct_reg;
    logic [fdmd_pkg::PML_W-1:0] qty_pml_reg;
    logic [CDW-1:0]             width_reg, height_reg;

    // tol, area refresh at the write so a request right after sees them; thr_reg lags them
    logic [fdmd_pkg::TOL_W-1:0]    tol_reg;
    logic [fdmd_pkg::AREA_W-1:0]   area_reg;
    logic [fdmd_pkg::SCALED_W-1:0] thr_reg;

    logic           cfg_write;
    logic [CDW-1:0] width_eff, height_eff, wdata_eff;
    logic [2*CDW-1:0] area_w_next, area_h_next;
    logic [fdmd_pkg::SCALED_W-1:0] thr_next;

    fdmd_pkg::item_t front_item, back_item;
    logic            q_push, q_full, q_pop, q_valid;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // out-of-range sizes are clamped to 1 .. MAX_DIM
    assign width_eff  = fdmd_pkg::eff_dim(width_reg);
    assign height_eff = fdmd_pkg::eff_dim(height_reg);
    assign wdata_eff  = fdmd_pkg::eff_dim(pwdata[CDW-1:0]);

    // frame area for a new width or a new height
    assign area_w_next = (2*CDW)'(wdata_eff) * (2*CDW)'(height_eff);
    assign area_h_next = (2*CDW)'(width_eff) * (2*CDW)'(wdata_eff);

    // quantity threshold scaled by 1000, so no divide is needed at frame end
    assign thr_next = fdmd_pkg::SCALED_W'(area_reg) * fdmd_pkg::SCALED_W'(qty_pml_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_pct_reg <= fdmd_pkg::RST_TOL_PCT;
            qty_pml_reg <= fdmd_pkg::RST_QTY_PML;
            width_reg   <= fdmd_pkg::RST_WIDTH;
            height_reg  <= fdmd_pkg::RST_HEIGHT;
            tol_reg     <= fdmd_pkg::RST_TOL;
            area_reg    <= fdmd_pkg::RST_AREA;
            thr_reg     <= fdmd_pkg::RST_THR;
        end else begin
            thr_reg <= thr_next;
            if (cfg_write) begin
                unique case (fdmd_pkg::reg_idx_t'(paddr[3:2]))
                    fdmd_pkg::REG_TOL_PCT: begin
                        tol_pct_reg <= pwdata[fdmd_pkg::PCT_W-1:0];
                        tol_reg     <= fdmd_pkg::tol_of(pwdata[fdmd_pkg::PCT_W-1:0]);
                    end
                    fdmd_pkg::REG_QTY_PML: begin
                        qty_pml_reg <= pwdata[fdmd_pkg::PML_W-1:0];
                    end
                    fdmd_pkg::REG_WIDTH: begin
                        width_reg <= pwdata[CDW-1:0];
                        area_reg  <= area_w_next[fdmd_pkg::AREA_W-1:0];
                    end
                    fdmd_pkg::REG_HEIGHT: begin
                        height_reg <= pwdata[CDW-1:0];
                        area_reg   <= area_h_next[fdmd_pkg::AREA_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // register read back
    always_comb begin
        unique case (fdmd_pkg::reg_idx_t'(paddr[3:2]))
            fdmd_pkg::REG_TOL_PCT: prdata = 32'(tol_pct_reg);
            fdmd_pkg::REG_QTY_PML: prdata = 32'(qty_pml_reg);
            fdmd_pkg::REG_WIDTH:   prdata = 32'(width_reg);
            fdmd_pkg::REG_HEIGHT:  prdata = 32'(height_reg);
            default:               prdata = '0;
        endcase
    end

    // front: difference, tint and raster position
    fdmd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .tol        (tol_reg),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (front_item)
    );

    // two-entry queue decouples the classify side from the result side
    fdmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (back_item)
    );

    // back: count, bounding box, quantity check and output register
    fdmd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (back_item),
        .q_pop    (q_pop),
        .thr      (thr_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
